/* sv/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and constants of the UTF-8 transcoder
// Lead byte decode, per-length residues, surrogate constants, queue sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8u16_pkg;

    // output form register codes
    localparam logic FORM_UTF16 = 1'b0;
    localparam logic FORM_UTF32 = 1'b1;

    localparam logic [31:0] TILDE_CODE = 32'h0000_007E;
    localparam logic [31:0] BMP_MAX    = 32'h0000_FFFF;
    localparam logic [31:0] CODE_MAX   = 32'h0010_FFFF;
    localparam logic [31:0] SURR_BASE  = 32'h0001_0000;
    localparam logic [31:0] SURR_HIGH  = 32'h0000_D800;
    localparam logic [31:0] SURR_LOW   = 32'h0000_DC00;

    // result queue: room for two in-flight pairs plus the head
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [31:0] unit_out;
        logic        run_last;
        logic        string_end;
    } unit_t;

    // up to two units pushed per cycle, first goes out first
    typedef struct packed {
        logic [1:0] count;
        unit_t      first;
        unit_t      second;
    } push_t;

    function automatic logic [2:0] trail_count(input logic [7:0] lead);
        logic [2:0] n;
        if (lead < 8'hC0)
            n = 3'd0;
        else if (lead < 8'hE0)
            n = 3'd1;
        else if (lead < 8'hF0)
            n = 3'd2;
        else if (lead < 8'hF8)
            n = 3'd3;
        else if (lead < 8'hFC)
            n = 3'd4;
        else
            n = 3'd5;
        return n;
    endfunction

    function automatic logic [31:0] residue(input logic [2:0] seq_len);
        logic [31:0] r;
        unique case (seq_len)
            3'd1:    r = 32'h0000_3080;
            3'd2:    r = 32'h000E_2080;
            3'd3:    r = 32'h03C8_2080;
            3'd4:    r = 32'hFA08_2080;
            3'd5:    r = 32'h8208_2080;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

endpackage

/* sv/u8u16_byte_if.sv */
// ----------------------------------------------------------------------------
// u8u16_byte_if: UTF-8 byte channel
// Valid/ready channel carrying one byte and its end-of-string mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       string_last;

    modport source (output valid, output byte_in, output string_last, input ready);
    modport sink   (input valid, input byte_in, input string_last, output ready);
endinterface

/* sv/u8u16_unit_if.sv */
// ----------------------------------------------------------------------------
// u8u16_unit_if: result unit channel
// Valid/ready channel carrying one UTF-16 unit or UTF-32 value with marks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [31:0] unit_out;
    logic        run_last;
    logic        string_end;

    modport source (output valid, output unit_out, output run_last, output string_end,
                    input ready);
    modport sink   (input valid, input unit_out, input run_last, input string_end,
                    output ready);
endinterface

/* sv/u8u16_decode.sv */
// ----------------------------------------------------------------------------
// u8u16_decode: UTF-8 sequence decoder and output formatter
// Accumulates a sequence, registers the decoded value, then splits it
// into one unit or a surrogate pair for the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8u16_decode (
    input  logic                            clk,
    input  logic                            rst_n,
    u8u16_byte_if.sink                      byte_ch,
    input  logic                            output_form,
    input  logic [u8u16_pkg::QCNT_W-1:0]    queue_level,
    output u8u16_pkg::push_t                push
);
    import u8u16_pkg::*;

    logic [31:0] acc_reg, acc_next;
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  len_reg, len_next;

    logic        s1_valid_reg;
    logic [31:0] s1_value_reg;
    logic        s1_last_reg;

    logic        accept;
    logic        emit;
    logic [31:0] value;
    logic [31:0] acc_shift;
    logic [2:0]  lead_trail;
    logic [QCNT_W-1:0] reserved;
    logic [31:0] offset;

    // keep room for the pair in stage one plus a pair from this item
    assign reserved = queue_level + (s1_valid_reg ? QCNT_W'(2) : QCNT_W'(0));
    assign byte_ch.ready = (reserved <= QCNT_W'(QUEUE_DEPTH - 2));
    assign accept = byte_ch.valid && byte_ch.ready;

    assign acc_shift  = {acc_reg[25:0], 6'b0} + {24'b0, byte_ch.byte_in};
    assign lead_trail = trail_count(byte_ch.byte_in);

    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        len_next = len_reg;
        emit     = 1'b0;
        value    = TILDE_CODE;
        if (rem_reg == 3'd0)
        begin
            if (lead_trail == 3'd0)
            begin
                emit  = 1'b1;
                value = {24'b0, byte_ch.byte_in};
                acc_next = '0;
                len_next = '0;
            end
            else if (byte_ch.string_last)
            begin
                // sequence cut short by end of string
                emit = 1'b1;
                acc_next = '0;
                len_next = '0;
            end
            else
            begin
                acc_next = {24'b0, byte_ch.byte_in};
                rem_next = lead_trail;
                len_next = lead_trail;
            end
        end
        else if (rem_reg == 3'd1)
        begin
            emit     = 1'b1;
            value    = acc_shift - residue(len_reg);
            acc_next = '0;
            rem_next = '0;
            len_next = '0;
        end
        else if (byte_ch.string_last)
        begin
            emit     = 1'b1;
            acc_next = '0;
            rem_next = '0;
            len_next = '0;
        end
        else
        begin
            acc_next = acc_shift;
            rem_next = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            rem_reg      <= '0;
            len_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && emit;
            if (accept)
            begin
                acc_reg <= acc_next;
                rem_reg <= rem_next;
                len_reg <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg <= value;
            s1_last_reg  <= byte_ch.string_last;
        end
    end

    // format stage
    assign offset = s1_value_reg - SURR_BASE;

    always_comb
    begin
        push.first.unit_out    = s1_value_reg;
        push.first.run_last    = 1'b1;
        push.first.string_end  = s1_last_reg;
        push.second.unit_out   = SURR_LOW + {22'b0, offset[9:0]};
        push.second.run_last   = 1'b1;
        push.second.string_end = s1_last_reg;
        push.count             = s1_valid_reg ? 2'd1 : 2'd0;
        if (output_form == FORM_UTF16 && s1_value_reg > BMP_MAX)
        begin
            if (s1_value_reg > CODE_MAX)
                push.first.unit_out = TILDE_CODE;
            else
            begin
                push.first.unit_out   = SURR_HIGH + {22'b0, offset[19:10]};
                push.first.run_last   = 1'b0;
                push.first.string_end = 1'b0;
                push.count            = s1_valid_reg ? 2'd2 : 2'd0;
            end
        end
    end

endmodule

/* sv/u8u16_queue.sv */
// ----------------------------------------------------------------------------
// u8u16_queue: result unit queue
// Small register queue taking up to two units per cycle, one out per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8u16_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  u8u16_pkg::push_t                push,
    u8u16_unit_if.source                    unit_ch,
    output logic [u8u16_pkg::QCNT_W-1:0]    level
);
    import u8u16_pkg::*;

    unit_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  level_reg, level_next;
    logic               pop;
    logic [QPTR_W-1:0]  wr_ptr_plus1;
    unit_t              head;

    assign pop          = unit_ch.valid && unit_ch.ready;
    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
    assign level_next   = level_reg + QCNT_W'(push.count) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push.count);
            level_reg  <= level_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            slot_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            slot_reg[wr_ptr_plus1] <= push.second;
    end

    assign head               = slot_reg[rd_ptr_reg];
    assign unit_ch.valid      = (level_reg != '0);
    assign unit_ch.unit_out   = head.unit_out;
    assign unit_ch.run_last   = head.run_last;
    assign unit_ch.string_end = head.string_end;
    assign level              = level_reg;

endmodule

/* sv/utf8_to_utf16_transcoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder: UTF-8 to UTF-16 / UTF-32 stream transcoder
// Decodes UTF-8 bytes and emits UTF-16 units or raw 32-bit code values.
// ----------------------------------------------------------------------------
// Path: an accepted byte's decoded value is registered in stage one, then
// written into the queue, where it is valid and can be taken at the output.
// Throughput: one byte per cycle; a surrogate pair needs four bytes, so a
// ready receiver keeps up. Input pauses only under output stalls, once the
// 8-entry queue cannot take another pair.
// Reset: no sequence open, queue empty, output form UTF-16.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder (
    input  logic            clk,
    input  logic            rst_n,
    u8u16_byte_if.sink      byte_ch,
    u8u16_unit_if.source    unit_ch,
    input  logic            cfg_we,
    input  logic            cfg_wdata
);
    import u8u16_pkg::*;

    logic              form_reg;
    push_t             push;
    logic [QCNT_W-1:0] queue_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            form_reg <= FORM_UTF16;
        else if (cfg_we)
            form_reg <= cfg_wdata;
    end

    u8u16_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_ch     (byte_ch),
        .output_form (form_reg),
        .queue_level (queue_level),
        .push        (push)
    );

    u8u16_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .unit_ch (unit_ch),
        .level   (queue_level)
    );

    // queue never overruns
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_level <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overrun");

    // output valid exactly when the queue holds a unit
    assert property (@(posedge clk) disable iff (!rst_n)
        unit_ch.valid == (queue_level != '0))
        else $error("output valid disagrees with queue level");

    // a byte is only taken with room for a pair
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_ch.valid && byte_ch.ready) |-> queue_level <= QCNT_W'(QUEUE_DEPTH - 2))
        else $error("byte accepted without queue room");

    // a pair pushed last cycle raises the level unless a unit left
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2 && !(unit_ch.valid && unit_ch.ready))
            |=> queue_level == $past(queue_level) + QCNT_W'(2))
        else $error("surrogate pair lost in queue");

endmodule
